FILE: rtl/b64e_pkg.sv
package b64e_pkg;

  localparam int CharW     = 7;
  localparam int ByteW     = 8;
  localparam int MaxChars  = 4;
  localparam int CharIdxW  = $clog2(MaxChars);
  localparam int JobDepth  = 2;
  localparam int JobPtrW   = (JobDepth > 1) ? $clog2(JobDepth) : 1;
  localparam int JobCountW = $clog2(JobDepth + 1);

  localparam logic [CharW-1:0] PadCode = 7'd61;

  // One accepted byte turned into the characters it releases.
  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [CharIdxW-1:0]            last_idx;
    logic                           fin;
  } job_t;

  // Maps a 6-bit value onto the standard base64 alphabet.
  function automatic logic [CharW-1:0] sym(input logic [5:0] v);
    logic [CharW-1:0] v7;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      sym = 7'd65 + v7;
    end else if (v < 6'd52) begin
      sym = 7'd97 + v7 - 7'd26;
    end else if (v < 6'd62) begin
      sym = 7'd48 + v7 - 7'd52;
    end else if (v == 6'd62) begin
      sym = 7'd43;
    end else begin
      sym = 7'd47;
    end
  endfunction

endpackage

FILE: rtl/b64e_if.sv
interface b64e_in_if import b64e_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_out_if import b64e_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

FILE: rtl/b64e_front.sv
module b64e_front import b64e_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] in_data_byte,
  input  logic             in_final_byte,
  output logic             job_valid,
  input  logic             job_ready,
  output job_t             job
);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] left_r, left_nxt;
  logic       take;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign take      = in_valid && job_ready;

  always_comb begin
    job       = '0;
    phase_nxt = phase_r;
    left_nxt  = left_r;
    job.fin   = in_final_byte;
    unique case (phase_r)
      PH_SECOND: begin
        job.chars[0] = sym({left_r[1:0], in_data_byte[7:4]});
        if (in_final_byte) begin
          job.chars[1] = sym({in_data_byte[3:0], 2'b00});
          job.chars[2] = PadCode;
          job.last_idx = CharIdxW'(2);
          phase_nxt    = PH_FIRST;
          left_nxt     = '0;
        end else begin
          job.last_idx = CharIdxW'(0);
          phase_nxt    = PH_THIRD;
          left_nxt     = in_data_byte[3:0];
        end
      end
      PH_THIRD: begin
        job.chars[0] = sym({left_r, in_data_byte[7:6]});
        job.chars[1] = sym(in_data_byte[5:0]);
        job.last_idx = CharIdxW'(1);
        phase_nxt    = PH_FIRST;
        left_nxt     = '0;
      end
      default: begin
        job.chars[0] = sym(in_data_byte[7:2]);
        if (in_final_byte) begin
          job.chars[1] = sym({in_data_byte[1:0], 4'b0000});
          job.chars[2] = PadCode;
          job.chars[3] = PadCode;
          job.last_idx = CharIdxW'(3);
          phase_nxt    = PH_FIRST;
          left_nxt     = '0;
        end else begin
          job.last_idx = CharIdxW'(0);
          phase_nxt    = PH_SECOND;
          left_nxt     = {2'b00, in_data_byte[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      left_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

FILE: rtl/b64e_job_fifo.sv
module b64e_job_fifo import b64e_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t                 entry_r [JobDepth];
  logic [JobPtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [JobCountW-1:0] count_r;
  logic                 push, pop;

  assign push_ready = (count_r != JobCountW'(JobDepth));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [JobPtrW-1:0] bump(input logic [JobPtrW-1:0] p);
    if (p == JobPtrW'(JobDepth - 1)) begin
      bump = '0;
    end else begin
      bump = p + JobPtrW'(1);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + JobCountW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - JobCountW'(1);
      end
    end
  end

endmodule

FILE: rtl/b64e_back.sv
module b64e_back import b64e_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_ready,
  input  job_t             job,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CharW-1:0] out_char_code,
  output logic             out_end_of_text
);

  job_t                cur_r;
  logic                cur_valid_r;
  logic [CharIdxW-1:0] idx_r;
  logic                out_valid_r;
  logic [CharW-1:0]    out_char_r;
  logic                out_eot_r;
  logic                adv, last_char;

  // A character moves to the output register whenever that register is free
  // or is being emptied by a transfer in this cycle.
  assign adv       = cur_valid_r && (!out_valid_r || out_ready);
  assign last_char = (idx_r == cur_r.last_idx);
  assign job_ready = !cur_valid_r || (adv && last_char);

  assign out_valid       = out_valid_r;
  assign out_char_code   = out_char_r;
  assign out_end_of_text = out_eot_r;

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      cur_r <= job;
    end
    if (adv) begin
      out_char_r <= cur_r.chars[idx_r];
      out_eot_r  <= cur_r.fin && last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (job_ready) begin
        cur_valid_r <= job_valid;
        idx_r       <= '0;
      end else if (adv) begin
        idx_r <= idx_r + CharIdxW'(1);
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/base64_byte_stream_encoder.sv
// Base64 encoder for a byte stream: one raw byte comes in per input transfer,
// with final_byte set on the last byte of a message, and one ASCII character
// of the standard alphabet (A-Z, a-z, 0-9, '+', '/') goes out per output
// transfer. A message that ends inside a three-byte group is completed with
// '=' padding to a multiple of four characters, and end_of_text marks the
// last character of every message. After the final byte the encoder is back
// at the start of a group, so the next byte opens a new message. The input
// side takes one byte per cycle while the job queue has room; the output
// port sends one character per cycle while the sink is ready. A byte
// releases one character as the first or second byte of a group, two as
// the third, and two to four as a final byte. The output port is what
// bounds the sustained rate, since three bytes turn into four characters.
module base64_byte_stream_encoder import b64e_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  b64e_in_if.sink        in_chan,
  b64e_out_if.source     out_chan
);

  // The front end tracks the group position and the leftover low bits, and
  // turns each accepted byte into a job: up to four finished characters and
  // the index of the last one.
  logic job_in_valid, job_in_ready;
  job_t job_in;

  // The queue lets the front keep accepting bytes while the back end is
  // still draining characters of earlier jobs.
  logic job_out_valid, job_out_ready;
  job_t job_out;

  b64e_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_chan.valid),
    .in_ready      (in_chan.ready),
    .in_data_byte  (in_chan.data_byte),
    .in_final_byte (in_chan.final_byte),
    .job_valid     (job_in_valid),
    .job_ready     (job_in_ready),
    .job           (job_in)
  );

  b64e_job_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (job_in_valid),
    .push_ready (job_in_ready),
    .push_job   (job_in),
    .pop_valid  (job_out_valid),
    .pop_ready  (job_out_ready),
    .pop_job    (job_out)
  );

  // The back end walks through a job one character per cycle into a
  // registered output stage, which holds a character while the sink stalls.
  b64e_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (job_out_valid),
    .job_ready       (job_out_ready),
    .job             (job_out),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_char_code   (out_chan.char_code),
    .out_end_of_text (out_chan.end_of_text)
  );

endmodule

FILE: bench/b64e_stream_checker.sv
module b64e_stream_checker import b64e_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [ByteW-1:0] in_data_byte,
  input  logic             in_final_byte,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [CharW-1:0] out_char_code,
  input  logic             out_end_of_text,
  output int               fail_count,
  output int               pending_chars,
  output int               chars_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             eot;
  } enc_char_t;

  string alphabet_txt =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  enc_char_t  expected_chars[$];
  logic [1:0] grp_pos;
  logic [3:0] carry_bits;

  function automatic void push_code(input logic [CharW-1:0] code, input logic eot);
    enc_char_t c;
    c.code = code;
    c.eot  = eot;
    expected_chars.push_back(c);
  endfunction

  function automatic void push_sextet(input logic [5:0] v, input logic eot);
    byte unsigned ch;
    ch = alphabet_txt.getc(v);
    push_code(ch[CharW-1:0], eot);
  endfunction

  // Queues the characters that one byte releases and advances the group position.
  function automatic void encode_byte(input logic [ByteW-1:0] b, input logic fin);
    case (grp_pos)
      2'd1: begin
        push_sextet({carry_bits[1:0], b[7:4]}, 1'b0);
        if (fin) begin
          push_sextet({b[3:0], 2'b00}, 1'b0);
          push_code(PadCode, 1'b1);
        end else begin
          carry_bits = b[3:0];
          grp_pos    = 2'd2;
        end
      end
      2'd2: begin
        push_sextet({carry_bits, b[7:6]}, 1'b0);
        push_sextet(b[5:0], fin);
        grp_pos    = 2'd0;
        carry_bits = 4'd0;
      end
      default: begin
        push_sextet(b[7:2], 1'b0);
        if (fin) begin
          push_sextet({b[1:0], 4'b0000}, 1'b0);
          push_code(PadCode, 1'b0);
          push_code(PadCode, 1'b1);
        end else begin
          carry_bits = {2'b00, b[1:0]};
          grp_pos    = 2'd1;
        end
      end
    endcase
    if (fin) begin
      grp_pos    = 2'd0;
      carry_bits = 4'd0;
    end
  endfunction

  always @(posedge clk) begin
    enc_char_t want;
    if (!rst_n) begin
      grp_pos       = 2'd0;
      carry_bits    = 4'd0;
      fail_count    = 0;
      chars_checked = 0;
      expected_chars.delete();
    end else begin
      if (in_valid && in_ready) begin
        encode_byte(in_data_byte, in_final_byte);
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character: char_code %0d, end_of_text %0b",
                 out_char_code, out_end_of_text);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          chars_checked++;
          if (out_char_code !== want.code) begin
            $error("char_code mismatch: expected %0d, actual %0d", want.code, out_char_code);
            fail_count++;
          end
          if (out_end_of_text !== want.eot) begin
            $error("end_of_text mismatch: expected %0b, actual %0b",
                   want.eot, out_end_of_text);
            fail_count++;
          end
        end
      end
    end
    pending_chars = expected_chars.size();
  end

endmodule

FILE: bench/tb.sv
module tb import b64e_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // The run is cut off here; even the slowest legal run needs only a small
  // fraction of this many cycles.
  localparam int CycleLimit   = 100000;
  localparam int TotalBytes   = 160;
  localparam int CalmFromByte = 130;
  localparam int StallAtByte  = 60;
  localparam int StallCycles  = 80;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  b64e_in_if  in_chan();
  b64e_out_if out_chan();

  base64_byte_stream_encoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  int fail_count;
  int pending_chars;
  int chars_checked;

  // The checker watches both channels, predicts every character and compares.
  b64e_stream_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_chan.valid),
    .in_ready        (in_chan.ready),
    .in_data_byte    (in_chan.data_byte),
    .in_final_byte   (in_chan.final_byte),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_char_code   (out_chan.char_code),
    .out_end_of_text (out_chan.end_of_text),
    .fail_count      (fail_count),
    .pending_chars   (pending_chars),
    .chars_checked   (chars_checked)
  );

  // Idle bursts are allowed on both sides while this is set; the closing
  // stretch of the run clears it so the block also sees back-to-back traffic.
  bit idle_on = 1'b1;
  // Raised once by the sender; the receiver then holds off on its own.
  bit long_stall_req = 1'b0;
  int bytes_sent = 0;
  int msgs_sent  = 0;
  int cycle_count = 0;

  // Watchdog: a hung handshake or a lost character ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d characters outstanding",
               cycle_count, pending_chars);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offers one byte and returns at the falling edge after its transfer.
  // Valid is left high so the next byte can follow without a bubble.
  task automatic offer_byte(input logic [ByteW-1:0] b, input logic fin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_chan.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_chan.valid      = 1'b1;
    in_chan.data_byte  = b;
    in_chan.final_byte = fin;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Sends a whole message; only its last byte carries the final flag.
  task automatic send_message(input logic [ByteW-1:0] msg[$]);
    foreach (msg[i]) begin
      offer_byte(msg[i], i == msg.size() - 1);
    end
    msgs_sent++;
  endtask

  // Random bytes, with the all-zero and all-one patterns mixed in often.
  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver: ready bursts and idle bursts of random length, plus one long
  // hold-off so that the job queue fills and the input side stalls.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_chan.ready = 1'b0;
        repeat (StallCycles) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_chan.ready = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        out_chan.ready = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // Sender: reset, directed messages, then random messages.
  initial begin
    logic [ByteW-1:0] msg[$];
    int len;
    bit stall_done;

    stall_done         = 1'b0;
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.data_byte  = '0;
    in_chan.final_byte = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed part. A lone final byte gives two pads, a final second byte
    // one pad, and a final third byte none. The patterns reach the first
    // ('A') and last ('/') letters and '+', and messages of four and five
    // bytes close on a final byte that starts or continues a second group.
    send_message('{8'h00});
    send_message('{8'hFF});
    send_message('{8'hFF, 8'hFF});
    send_message('{8'h00, 8'hFF, 8'h80});
    send_message('{8'hFB, 8'hEF, 8'hBE, 8'h55});
    send_message('{8'h4D, 8'h61, 8'h6E, 8'h01, 8'h80});

    // Random part: messages of mostly short length, now and then a longer one.
    while (bytes_sent < TotalBytes) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      msg.delete();
      repeat (len) msg.push_back(pick_byte());
      if (!stall_done && bytes_sent >= StallAtByte) begin
        // The sender keeps offering bytes while the receiver holds off.
        long_stall_req = 1'b1;
        stall_done     = 1'b1;
      end
      if (bytes_sent >= CalmFromByte) begin
        idle_on = 1'b0;
      end
      send_message(msg);
    end
    in_chan.valid      = 1'b0;
    in_chan.final_byte = 1'b0;

    // Drain: the watchdog catches a result that never comes.
    while (pending_chars != 0) @(negedge clk);
    // Give a stray extra character time to show up.
    repeat (20) @(negedge clk);

    $display("Encoded %0d bytes in %0d messages; %0d characters checked.",
             bytes_sent, msgs_sent, chars_checked);
    $display("Final bytes at every group position, idle bursts on both sides, one long stall.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
